@@ hdl/tked_pkg.sv @@
// types, constants and key lookup functions for the terminal key escape decoder
package tked_pkg;

	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SS3   = 8'h4F;	// 'O'
	localparam logic [7:0] CH_CSI   = 8'h5B;	// '['
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_HOME  = 8'h48;	// 'H'
	localparam logic [7:0] CH_END   = 8'h46;	// 'F'
	localparam logic [7:0] CH_UP    = 8'h41;	// 'A'
	localparam logic [7:0] CH_DOWN  = 8'h42;
	localparam logic [7:0] CH_RIGHT = 8'h43;
	localparam logic [7:0] CH_LEFT  = 8'h44;
	localparam logic [7:0] CH_F1    = 8'h50;	// 'P'
	localparam logic [7:0] CH_F4    = 8'h53;	// 'S'
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [6:0] ARG_MAX = 7'd99;

	localparam logic [4:0] KEY_HOME  = 5'd0;
	localparam logic [4:0] KEY_END   = 5'd1;
	localparam logic [4:0] KEY_UP    = 5'd2;
	localparam logic [4:0] KEY_DOWN  = 5'd3;
	localparam logic [4:0] KEY_RIGHT = 5'd4;
	localparam logic [4:0] KEY_LEFT  = 5'd5;
	localparam logic [4:0] KEY_PGUP  = 5'd6;
	localparam logic [4:0] KEY_PGDN  = 5'd7;
	localparam logic [4:0] KEY_F1    = 5'd8;
	localparam logic [4:0] KEY_F5    = 5'd12;
	localparam logic [4:0] KEY_F6    = 5'd13;
	localparam logic [4:0] KEY_F7    = 5'd14;
	localparam logic [4:0] KEY_F8    = 5'd15;
	localparam logic [4:0] KEY_F9    = 5'd16;
	localparam logic [4:0] KEY_F10   = 5'd17;
	localparam logic [4:0] KEY_F11   = 5'd18;
	localparam logic [4:0] KEY_F12   = 5'd19;
	localparam logic [7:0] KEY_CODE_MAX = 8'd19;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_ESC  = 2'd1,
		PH_SEQ  = 2'd2
	} phase_t;

	typedef struct packed {
		logic       is_key;
		logic [7:0] value;
		logic       last;
	} result_t;

	typedef struct packed {
		logic       hit;
		logic [4:0] code;
	} key_lookup_t;

	function automatic key_lookup_t tilde_key(input logic [6:0] arg);
		key_lookup_t k;
		k.hit = 1'b1;
		case (arg)
			7'd5:    k.code = KEY_PGUP;
			7'd6:    k.code = KEY_PGDN;
			7'd15:   k.code = KEY_F5;
			7'd17:   k.code = KEY_F6;
			7'd18:   k.code = KEY_F7;
			7'd19:   k.code = KEY_F8;
			7'd20:   k.code = KEY_F9;
			7'd21:   k.code = KEY_F10;
			7'd23:   k.code = KEY_F11;
			7'd24:   k.code = KEY_F12;
			default: begin
				k.hit  = 1'b0;
				k.code = KEY_HOME;
			end
		endcase
		return k;
	endfunction

	function automatic key_lookup_t final_key(input logic [7:0] b, input logic ss3,
			input logic [6:0] arg);
		key_lookup_t k;
		k.hit  = 1'b1;
		k.code = KEY_HOME;
		if (b == CH_HOME) begin
			k.code = KEY_HOME;
		end else if (b == CH_END) begin
			k.code = KEY_END;
		end else if (ss3) begin
			if (b >= CH_F1 && b <= CH_F4) begin
				k.code = KEY_F1 + 5'(b[1:0]);
			end else begin
				k.hit = 1'b0;
			end
		end else begin
			case (b)
				CH_UP:    k.code = KEY_UP;
				CH_DOWN:  k.code = KEY_DOWN;
				CH_RIGHT: k.code = KEY_RIGHT;
				CH_LEFT:  k.code = KEY_LEFT;
				CH_TILDE: k = tilde_key(arg);
				default:  k.hit = 1'b0;
			endcase
		end
		return k;
	endfunction

endpackage

@@ hdl/terminal_key_escape_decoder.sv @@
// Terminal key escape decoder: raw terminal bytes in, characters and key codes out
//
// Input channel: in_valid / in_stall / in_byte, one raw terminal byte per transfer.
// Output channel: out_valid / out_stall / is_key, value, last. A byte gives zero,
// one or two results; last marks the final result of a byte. ESC, introducer and
// argument digits give none; a broken sequence gives ESC and then one character.
// Path: a byte taken into the input register is decoded there and its results are
// written into the result queue, whose head slot0 drives the output.
// Throughput: one byte per cycle while its results fit in the queue. The output side
// runs through a two-entry result queue, and a byte whose results do not fit there
// stalls the input. The sequence state (phase, introducer, decimal argument) is
// updated in the same cycle a byte moves from the input register into the queue.
// While out_stall is high results wait in the queue and in_stall rises as soon as
// the input register cannot empty; results are never dropped or repeated.
// Reset (arst_n low) empties the input register and the queue and returns the
// decoder to idle outside any sequence.
module terminal_key_escape_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       is_key,
	output logic [7:0] value,
	output logic       last
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	tked_pkg::phase_t      phase_q, phase_nx;
	logic                  ss3_q, ss3_nx;
	logic [6:0]            arg_q, arg_nx;
	tked_pkg::result_t     slot0_q, slot1_q, slot0_nx, slot1_nx;
	logic [1:0]            count_q, count_nx;

	logic                  in_xfer, out_xfer, adv;
	logic [1:0]            n_res, rem;
	logic [2:0]            need;
	tked_pkg::result_t     r0, r1;
	tked_pkg::key_lookup_t key;
	logic [9:0]            arg_x;
	logic [9:0]            arg_sum;

	// decode of the byte in the input register
	always_comb begin
		phase_nx = phase_q;
		ss3_nx   = ss3_q;
		arg_nx   = arg_q;
		n_res    = 2'd0;
		r0       = '{is_key: 1'b0, value: tked_pkg::CH_ESC, last: 1'b0};
		r1       = '{is_key: 1'b0, value: byte_s1, last: 1'b1};
		arg_x    = {3'b000, arg_q};
		arg_sum  = (arg_x << 3) + (arg_x << 1) + {6'd0, byte_s1[3:0]};
		key      = tked_pkg::final_key(byte_s1, ss3_q, arg_q);
		case (phase_q)
			tked_pkg::PH_ESC: begin
				if (byte_s1 == tked_pkg::CH_SS3 || byte_s1 == tked_pkg::CH_CSI) begin
					ss3_nx   = (byte_s1 == tked_pkg::CH_SS3);
					arg_nx   = '0;
					phase_nx = tked_pkg::PH_SEQ;
				end else begin
					phase_nx = tked_pkg::PH_IDLE;
					n_res    = 2'd2;
				end
			end
			tked_pkg::PH_SEQ: begin
				if (byte_s1 >= tked_pkg::CH_ZERO && byte_s1 <= tked_pkg::CH_NINE) begin
					arg_nx = (arg_sum > {3'b000, tked_pkg::ARG_MAX}) ? tked_pkg::ARG_MAX
						: arg_sum[6:0];
				end else begin
					phase_nx = tked_pkg::PH_IDLE;
					if (key.hit) begin
						n_res = 2'd1;
						r0    = '{is_key: 1'b1, value: {3'b000, key.code}, last: 1'b1};
					end else begin
						// unknown final byte: ESC then the introducer, rest dropped
						n_res    = 2'd2;
						r1.value = ss3_q ? tked_pkg::CH_SS3 : tked_pkg::CH_CSI;
					end
				end
			end
			default: begin
				phase_nx = tked_pkg::PH_IDLE;
				if (byte_s1 == tked_pkg::CH_ESC) begin
					phase_nx = tked_pkg::PH_ESC;
				end else begin
					n_res = 2'd1;
					r0    = '{is_key: 1'b0,
						value: (byte_s1 == tked_pkg::CH_NL) ? tked_pkg::CH_CR : byte_s1,
						last: 1'b1};
				end
			end
		endcase
	end

	// result queue, slot0 is the head shown on the output
	assign out_valid = (count_q != 2'd0);
	assign is_key    = slot0_q.is_key;
	assign value     = slot0_q.value;
	assign last      = slot0_q.last;
	assign out_xfer  = out_valid && !out_stall;
	assign rem       = count_q - {1'b0, out_xfer};
	assign need      = {1'b0, rem} + {1'b0, n_res};
	assign adv       = valid_s1 && (need <= 3'd2);
	assign in_stall  = valid_s1 && !adv;
	assign in_xfer   = in_valid && !in_stall;

	always_comb begin
		slot0_nx = out_xfer ? slot1_q : slot0_q;
		slot1_nx = slot1_q;
		count_nx = rem;
		if (adv) begin
			count_nx = need[1:0];
			if (rem == 2'd0) begin
				slot0_nx = r0;
				slot1_nx = r1;
			end else if (n_res != 2'd0) begin
				// a byte with no results leaves a non-empty queue alone
				slot1_nx = r0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			count_q  <= 2'd0;
			phase_q  <= tked_pkg::PH_IDLE;
			ss3_q    <= 1'b0;
			arg_q    <= '0;
		end else begin
			count_q <= count_nx;
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				phase_q <= phase_nx;
				ss3_q   <= ss3_nx;
				arg_q   <= arg_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= in_byte;
		end
		slot0_q <= slot0_nx;
		slot1_q <= slot1_nx;
	end

endmodule

@@ hdl/tked_checker.sv @@
// port-level checks for the terminal key escape decoder, bound to the top level
module tked_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       is_key,
	input logic [7:0] value,
	input logic       last
);

	// a stalled result stays offered
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output valid dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(is_key) && $stable(value) && $stable(last))
		else $error("stalled output payload changed");

	// the second result of a byte is already queued when the first is transferred
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid && last)
		else $error("first of a result pair not followed by its partner");

	a_pair_head_esc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !is_key && value == tked_pkg::CH_ESC)
		else $error("non-final result is not a plain escape");

	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_key |-> last && value <= tked_pkg::KEY_CODE_MAX)
		else $error("key code out of range or not final");

endmodule

bind terminal_key_escape_decoder tked_checker u_tked_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.is_key    (is_key),
	.value     (value),
	.last      (last)
);
